/* hw/rtl/bhpw_pkg.sv */
`timescale 1ns / 1ps

package bhpw_pkg;

    localparam int DEBOUNCE_W = 16;
    localparam int HOLD_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DEBOUNCE_W-1:0] SINCE_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUTTON_ENABLE    = 3'd0,
        REG_ACTIVE_LOW       = 3'd1,
        REG_DEBOUNCE_TICKS   = 3'd2,
        REG_OPEN_HOLD_TICKS  = 3'd3,
        REG_CLEAR_HOLD_TICKS = 3'd4,
        REG_WINDOW_TICKS     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic button_level;
        logic pair_request;
        logic clear_request;
    } tick_word_t;

    typedef struct packed {
        logic stable_pressed;
        logic window_open;
        logic window_started;
        logic clear_hosts;
    } result_word_t;

    typedef struct packed {
        logic                  button_enable;
        logic                  active_low;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [HOLD_W-1:0]     open_hold_ticks;
        logic [HOLD_W-1:0]     clear_hold_ticks;
        logic [HOLD_W-1:0]     window_ticks;
    } cfg_regs_t;

endpackage

/* hw/rtl/button_hold_pairing_window.sv */
`timescale 1ns / 1ps

// debounced long-press detector with a timed pairing window
// tick channel: one word per timer tick (raw button level, pair and clear
//   requests), taken when tick_valid is high and tick_stall is low
// result channel: one word per tick (debounced state, window open, window
//   started pulse, clear-hosts pulse), taken when result_valid is high and
//   result_stall is low
// cfg channel: register index and data, written when cfg_valid and cfg_ready;
//   cfg_ready is always high, writes are meant only while the block is idle
// result timing: the result word is registered and appears in the cycle after its tick is taken
// throughput: one tick per cycle while tick_stall is low; all state update is
//   combinational counter and compare logic in front of the result register
// stall: tick_stall rises only while a result is held and result_stall is
//   high; the next tick is taken in the same cycle the held result leaves
// reset: config registers return to their defaults, the button reads as
//   released, the window is closed and the result register is empty
module button_hold_pairing_window
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  bhpw_pkg::tick_word_t            tick_word,
    output logic                            result_valid,
    input  logic                            result_stall,
    output bhpw_pkg::result_word_t          result_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bhpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bhpw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bhpw_pkg::*;

    cfg_regs_t    cfg_regs;
    result_word_t core_result;
    result_word_t result_word_reg;
    logic         result_valid_reg, result_valid_next;
    logic         accept;

    assign tick_stall = result_valid_reg && result_stall;
    assign accept     = tick_valid && !tick_stall;

    bhpw_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg_regs)
    );

    bhpw_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .tick   (tick_word),
        .cfg    (cfg_regs),
        .result (core_result)
    );

    always_comb
    begin
        if (accept)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_word_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted tick produced no result word");

    a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !tick_stall)
        else $error("tick channel stalled with empty result register");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && !$past(accept))
        else $error("stalled result word lost or overwritten");

endmodule

/* hw/rtl/bhpw_cfg.sv */
`timescale 1ns / 1ps

module bhpw_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bhpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bhpw_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bhpw_pkg::cfg_regs_t                 cfg_regs
);
    import bhpw_pkg::*;

    cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign cfg_regs  = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.button_enable    <= 1'b1;
            regs_reg.active_low       <= 1'b1;
            regs_reg.debounce_ticks   <= DEBOUNCE_W'(30);
            regs_reg.open_hold_ticks  <= HOLD_W'(3000);
            regs_reg.clear_hold_ticks <= HOLD_W'(10000);
            regs_reg.window_ticks     <= HOLD_W'(60000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_BUTTON_ENABLE:    regs_reg.button_enable    <= cfg_data[0];
                REG_ACTIVE_LOW:       regs_reg.active_low       <= cfg_data[0];
                REG_DEBOUNCE_TICKS:   regs_reg.debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
                REG_OPEN_HOLD_TICKS:  regs_reg.open_hold_ticks  <= cfg_data[HOLD_W-1:0];
                REG_CLEAR_HOLD_TICKS: regs_reg.clear_hold_ticks <= cfg_data[HOLD_W-1:0];
                REG_WINDOW_TICKS:     regs_reg.window_ticks     <= cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/bhpw_core.sv */
`timescale 1ns / 1ps

module bhpw_core
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  bhpw_pkg::tick_word_t   tick,
    input  bhpw_pkg::cfg_regs_t    cfg,
    output bhpw_pkg::result_word_t result
);
    import bhpw_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   db_reg, db_next;
    logic [DEBOUNCE_W-1:0]  since_reg, since_next;
    logic [COUNT_WIDTH-1:0] held_reg, held_next;
    logic                   open_done_reg, open_done_next;
    logic                   clear_done_reg, clear_done_next;
    logic [COUNT_WIDTH-1:0] win_reg, win_next;

    logic                   pressed;
    logic                   started;
    logic                   clear_pulse;
    logic [COUNT_WIDTH-1:0] win_load;
    logic [CMP_W-1:0]       held_ext;

    always_comb
    begin
        if (CMP_W'(cfg.window_ticks) > CMP_W'(COUNT_MAX))
            win_load = COUNT_MAX;
        else
            win_load = COUNT_WIDTH'(cfg.window_ticks);
    end

    always_comb
    begin
        started     = 1'b0;
        clear_pulse = 1'b0;
        pressed     = cfg.active_low ? ~tick.button_level : tick.button_level;

        win_next        = (win_reg != '0) ? win_reg - 1'b1 : win_reg;
        since_next      = (since_reg != SINCE_MAX) ? since_reg + 1'b1 : since_reg;
        held_next       = (db_reg && held_reg != COUNT_MAX) ? held_reg + 1'b1 : held_reg;
        db_next         = db_reg;
        open_done_next  = open_done_reg;
        clear_done_next = clear_done_reg;

        if (!cfg.button_enable)
        begin
            db_next         = 1'b0;
            held_next       = '0;
            open_done_next  = 1'b0;
            clear_done_next = 1'b0;
        end
        else
        begin
            if (pressed != db_reg && since_next >= cfg.debounce_ticks)
            begin
                db_next         = pressed;
                since_next      = '0;
                held_next       = '0;
                open_done_next  = 1'b0;
                clear_done_next = 1'b0;
            end
        end

        held_ext = CMP_W'(held_next);

        if (cfg.button_enable && db_next)
        begin
            if (held_ext >= CMP_W'(cfg.clear_hold_ticks) && !clear_done_next)
            begin
                clear_pulse     = 1'b1;
                started         = 1'b1;
                clear_done_next = 1'b1;
            end
            else if (held_ext >= CMP_W'(cfg.open_hold_ticks) && !open_done_next)
            begin
                started        = 1'b1;
                open_done_next = 1'b1;
            end
        end

        if (tick.pair_request)
            started = 1'b1;
        if (tick.clear_request)
        begin
            clear_pulse = 1'b1;
            started     = 1'b1;
        end
        if (started)
            win_next = win_load;

        result.stable_pressed = db_next;
        result.window_open    = (win_next != '0);
        result.window_started = started;
        result.clear_hosts    = clear_pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_reg         <= 1'b0;
            since_reg      <= SINCE_MAX;
            held_reg       <= '0;
            open_done_reg  <= 1'b0;
            clear_done_reg <= 1'b0;
            win_reg        <= '0;
        end
        else if (accept)
        begin
            db_reg         <= db_next;
            since_reg      <= since_next;
            held_reg       <= held_next;
            open_done_reg  <= open_done_next;
            clear_done_reg <= clear_done_next;
            win_reg        <= win_next;
        end
    end

    a_disabled_releases: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg.button_enable |=> !db_reg && held_reg == '0)
        else $error("button disabled but debounced state not released");

    a_clear_starts_window: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.clear_hosts |-> result.window_started)
        else $error("clear pulse without window start");

    a_window_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && started |=> win_reg == $past(win_load))
        else $error("window count not loaded on start");

    a_debounce_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cfg.button_enable && db_next != db_reg |=> since_reg == '0)
        else $error("accepted level change did not restart debounce timer");

endmodule
